// File: rtl/core/fvhd_pkg.sv
package fvhd_pkg;

  localparam int FTR_WORDS = 64;
  localparam int IDX_W     = 6;
  localparam int SUM_W     = 17;
  localparam int SECT_W    = 28;
  localparam int DIV_STEPS = 28;
  localparam int CNT_W     = 5;
  localparam int LANES     = 4;
  localparam int RECIP_W   = 29;
  localparam int PROD_W    = SECT_W + RECIP_W;

  localparam logic [63:0] COOKIE_WORD      = 64'h636F_6E65_6374_6978;
  localparam logic [31:0] CREATOR_APP_TAG  = 32'h7670_686E;
  localparam logic [31:0] CREATOR_HOST_TAG = 32'h5769_326B;
  localparam logic [31:0] FEATURES_VAL     = 32'h0000_0002;
  localparam logic [31:0] VERSION_VAL      = 32'h0001_0000;
  localparam logic [63:0] DATA_OFFSET_VAL  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] DISK_TYPE_FIXED  = 32'h0000_0002;
  localparam logic [62:0] EPOCH_2000       = 63'd946684800;
  localparam logic [31:0] STAMP_MAX        = 32'hFFFF_FFFF;
  localparam logic [63:0] SIZE_LIMIT       = 64'h7FFF_FFFF_FFFF_FDFF;
  localparam logic [SECT_W-1:0] MAX_SECTORS = 28'd267382800;
  localparam logic [SECT_W-1:0] BIG_SECTORS = 28'd66059280;

  // Sector-per-track candidates, one per reciprocal lane.
  localparam logic [7:0] SPT_A = 8'd17;
  localparam logic [7:0] SPT_B = 8'd31;
  localparam logic [7:0] SPT_C = 8'd63;
  localparam logic [7:0] SPT_D = 8'd255;

  // Rounded-up reciprocals of the candidates; the product shifted right gives the
  // exact quotient for every sector count below 2^28.
  localparam logic [RECIP_W-1:0] RECIP_A = 29'd505290271;
  localparam logic [RECIP_W-1:0] RECIP_B = 29'd277094665;
  localparam logic [RECIP_W-1:0] RECIP_C = 29'd272696337;
  localparam logic [RECIP_W-1:0] RECIP_D = 29'd269488145;
  localparam int RSH_A = 33;
  localparam int RSH_B = 33;
  localparam int RSH_C = 34;
  localparam int RSH_D = 36;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_ALIGN = 2'd2,
    ST_LARGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_PREP,
    FR_DIV1,
    FR_SEL,
    FR_DIV2,
    FR_SUM
  } front_state_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] size;
    logic [31:0] stamp;
    logic [31:0] chs;
    logic [63:0] uid_hi;
    logic [63:0] uid_lo;
    logic [31:0] chk;
  } fvhd_entry_t;

  function automatic logic [SUM_W-1:0] byte_sum64(input logic [63:0] w);
    logic [SUM_W-1:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + SUM_W'(w[8*i +: 8]);
    end
    return s;
  endfunction

  // Byte sum of every footer field that never changes.
  localparam logic [SUM_W-1:0] FIXED_SUM =
      byte_sum64(COOKIE_WORD) + byte_sum64({FEATURES_VAL, VERSION_VAL}) +
      byte_sum64(DATA_OFFSET_VAL) + byte_sum64({32'h0, CREATOR_APP_TAG}) +
      byte_sum64({VERSION_VAL, CREATOR_HOST_TAG}) + byte_sum64({32'h0, DISK_TYPE_FIXED});

endpackage

// File: rtl/core/fvhd_front.sv
module fvhd_front
  import fvhd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_raw_size,
  input  logic [62:0] in_unix_time,
  input  logic [63:0] in_uid_high,
  input  logic [63:0] in_uid_low,
  input  logic        q_full,
  output logic        q_push,
  output fvhd_entry_t q_data
);

  front_state_t state_r, state_nxt;

  logic [63:0]        size_r, size_nxt;
  logic [62:0]        time_r, time_nxt;
  logic [63:0]        uh_r, uh_nxt;
  logic [63:0]        ul_r, ul_nxt;
  logic [31:0]        stamp_r, stamp_nxt;
  logic [SUM_W-1:0]   sum_a_r, sum_a_nxt;
  logic [SECT_W-1:0]  sect_r, sect_nxt;
  logic [SECT_W-1:0]  dvd_r, dvd_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [7:0]         spt_r, spt_nxt;
  logic [4:0]         hd_r, hd_nxt;
  logic [4:0]         rem_r, rem_nxt;
  logic [SECT_W-1:0]  cyl_r, cyl_nxt;
  logic [SECT_W-1:0]  quo_r [LANES];
  logic [SECT_W-1:0]  quo_nxt [LANES];
  logic [SECT_W-1:0]  quo_c [LANES];
  logic [PROD_W-1:0]  prod_c [LANES];
  logic [5:0]         trial;
  logic               ge;
  logic [4:0]         rem_step;
  logic [SECT_W-1:0]  cyl_step;

  status_t            status_c;
  logic [62:0]        delta_c;
  logic [31:0]        stamp_c;
  logic [SECT_W-1:0]  sect_c;

  logic [18:0]        hd0, hd0c, hd_a;
  logic               c1, c2, big;
  logic [SECT_W-1:0]  cth_a, cth_f;
  logic [4:0]         hd_f;
  logic [7:0]         spt_f;
  logic [31:0]        chs_c;
  logic [SUM_W-1:0]   sum_c;

  // Size checks, in priority order.
  always_comb begin
    if (size_r == 64'd0) begin
      status_c = ST_EMPTY;
    end else if (size_r[8:0] != 9'd0) begin
      status_c = ST_ALIGN;
    end else if (size_r > SIZE_LIMIT) begin
      status_c = ST_LARGE;
    end else begin
      status_c = ST_OK;
    end
  end

  assign delta_c = time_r - EPOCH_2000;
  assign stamp_c = (time_r <= EPOCH_2000) ? 32'd0 :
                   (delta_c > 63'(STAMP_MAX)) ? STAMP_MAX : delta_c[31:0];
  assign sect_c  = (size_r[63:9] > 55'(MAX_SECTORS)) ? MAX_SECTORS : size_r[36:9];

  // Sector count over each track size by reciprocal multiplication.
  always_comb begin
    prod_c[0] = PROD_W'(sect_r) * PROD_W'(RECIP_A);
    prod_c[1] = PROD_W'(sect_r) * PROD_W'(RECIP_B);
    prod_c[2] = PROD_W'(sect_r) * PROD_W'(RECIP_C);
    prod_c[3] = PROD_W'(sect_r) * PROD_W'(RECIP_D);
    quo_c[0]  = SECT_W'(prod_c[0] >> RSH_A);
    quo_c[1]  = SECT_W'(prod_c[1] >> RSH_B);
    quo_c[2]  = SECT_W'(prod_c[2] >> RSH_C);
    quo_c[3]  = SECT_W'(prod_c[3] >> RSH_D);
  end

  // Restoring division of the cylinder-head count by the head count,
  // one quotient bit per cycle.
  always_comb begin
    trial    = {rem_r, dvd_r[SECT_W-1]};
    ge       = trial >= {1'b0, hd_r};
    rem_step = ge ? 5'(trial - {1'b0, hd_r}) : trial[4:0];
    cyl_step = {cyl_r[SECT_W-2:0], ge};
  end

  // Geometry choice from the four quotients of the sector count.
  assign big   = sect_r >= BIG_SECTORS;
  assign hd0   = 19'((29'(quo_r[0]) + 29'd1023) >> 10);
  assign hd0c  = (hd0 < 19'd4) ? 19'd4 : hd0;
  assign c1    = ({1'b0, quo_r[0]} >= {hd0c, 10'b0}) || (hd0c > 19'd16);
  assign cth_a = c1 ? quo_r[1] : quo_r[0];
  assign hd_a  = c1 ? 19'd16 : hd0c;
  assign c2    = {1'b0, cth_a} >= {hd_a, 10'b0};

  always_comb begin
    if (big) begin
      cth_f = quo_r[3];
      hd_f  = 5'd16;
      spt_f = SPT_D;
    end else if (c2) begin
      cth_f = quo_r[2];
      hd_f  = 5'd16;
      spt_f = SPT_C;
    end else begin
      cth_f = cth_a;
      hd_f  = hd_a[4:0];
      spt_f = c1 ? SPT_B : SPT_A;
    end
  end

  assign chs_c = {cyl_r[15:0], 3'b000, hd_r, spt_r};
  assign sum_c = sum_a_r + byte_sum64({stamp_r, 32'h0}) + byte_sum64({chs_c, 32'h0});

  always_comb begin
    state_nxt = state_r;
    size_nxt  = size_r;
    time_nxt  = time_r;
    uh_nxt    = uh_r;
    ul_nxt    = ul_r;
    stamp_nxt = stamp_r;
    sum_a_nxt = sum_a_r;
    sect_nxt  = sect_r;
    dvd_nxt   = dvd_r;
    cnt_nxt   = cnt_r;
    spt_nxt   = spt_r;
    hd_nxt    = hd_r;
    rem_nxt   = rem_r;
    cyl_nxt   = cyl_r;
    quo_nxt   = quo_r;
    busy      = 1'b1;
    q_push    = 1'b0;
    q_data        = '0;
    q_data.status = status_c;

    unique case (state_r)
      FR_IDLE: begin
        busy = 1'b0;
        if (start) begin
          size_nxt  = in_raw_size;
          time_nxt  = in_unix_time;
          uh_nxt    = in_uid_high;
          ul_nxt    = in_uid_low;
          state_nxt = FR_PREP;
        end
      end
      FR_PREP: begin
        stamp_nxt  = stamp_c;
        sum_a_nxt  = FIXED_SUM + (byte_sum64(size_r) << 1) + byte_sum64(uh_r) +
                     byte_sum64(ul_r);
        sect_nxt   = sect_c;
        if (status_c != ST_OK) begin
          // A bad size goes straight to the queue as a single error beat.
          if (!q_full) begin
            q_push    = 1'b1;
            state_nxt = FR_IDLE;
          end
        end else begin
          state_nxt = FR_DIV1;
        end
      end
      FR_DIV1: begin
        quo_nxt   = quo_c;
        state_nxt = FR_SEL;
      end
      FR_SEL: begin
        spt_nxt   = spt_f;
        hd_nxt    = hd_f;
        dvd_nxt   = cth_f;
        rem_nxt   = '0;
        cyl_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = FR_DIV2;
      end
      FR_DIV2: begin
        dvd_nxt = dvd_r << 1;
        rem_nxt = rem_step;
        cyl_nxt = cyl_step;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = FR_SUM;
        end
      end
      FR_SUM: begin
        q_data.size   = size_r;
        q_data.stamp  = stamp_r;
        q_data.chs    = chs_c;
        q_data.uid_hi = uh_r;
        q_data.uid_lo = ul_r;
        q_data.chk    = ~{{(32 - SUM_W){1'b0}}, sum_c};
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = FR_IDLE;
        end
      end
      default: state_nxt = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r  <= size_nxt;
    time_r  <= time_nxt;
    uh_r    <= uh_nxt;
    ul_r    <= ul_nxt;
    stamp_r <= stamp_nxt;
    sum_a_r <= sum_a_nxt;
    sect_r  <= sect_nxt;
    dvd_r   <= dvd_nxt;
    cnt_r   <= cnt_nxt;
    spt_r   <= spt_nxt;
    hd_r    <= hd_nxt;
    rem_r   <= rem_nxt;
    cyl_r   <= cyl_nxt;
    quo_r   <= quo_nxt;
  end

endmodule

// File: rtl/core/fvhd_fifo.sv
module fvhd_fifo
  import fvhd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  fvhd_entry_t push_data,
  output logic        full,
  input  logic        pop,
  output logic        head_valid,
  output fvhd_entry_t head
);

  fvhd_entry_t mem_r [2];
  logic        wptr_r, wptr_nxt;
  logic        rptr_r, rptr_nxt;
  logic [1:0]  count_r, count_nxt;

  assign full       = count_r == 2'd2;
  assign head_valid = count_r != 2'd0;
  assign head       = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r ^ push;
    rptr_nxt  = rptr_r ^ pop;
    count_nxt = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
      push |-> !full || pop)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
      pop |-> head_valid)
    else $error("queue read while empty");

endmodule

// File: rtl/core/fvhd_back.sv
module fvhd_back
  import fvhd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  fvhd_entry_t       head,
  output logic              pop,
  output logic              out_strobe,
  output logic [63:0]       out_footer_word,
  output logic [IDX_W-1:0]  out_word_index,
  output logic              out_last,
  output logic [1:0]        out_status,
  output logic [31:0]       out_checksum
);

  fvhd_entry_t       cur_r, cur_nxt;
  logic              active_r, active_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              strobe_r, strobe_nxt;
  logic [63:0]       word_r, word_nxt;
  logic [IDX_W-1:0]  oidx_r, oidx_nxt;
  logic              last_r, last_nxt;
  status_t           status_r, status_nxt;
  logic [31:0]       chk_r, chk_nxt;
  logic              is_err;
  logic              is_last;
  logic [63:0]       word_c;

  assign is_err  = cur_r.status != ST_OK;
  assign is_last = active_r && (is_err || idx_r == IDX_W'(FTR_WORDS - 1));
  assign pop     = head_valid && (!active_r || is_last);

  always_comb begin
    case (idx_r)
      6'd0:    word_c = COOKIE_WORD;
      6'd1:    word_c = {FEATURES_VAL, VERSION_VAL};
      6'd2:    word_c = DATA_OFFSET_VAL;
      6'd3:    word_c = {cur_r.stamp, CREATOR_APP_TAG};
      6'd4:    word_c = {VERSION_VAL, CREATOR_HOST_TAG};
      6'd5:    word_c = cur_r.size;
      6'd6:    word_c = cur_r.size;
      6'd7:    word_c = {cur_r.chs, DISK_TYPE_FIXED};
      6'd8:    word_c = {cur_r.chk, cur_r.uid_hi[63:32]};
      6'd9:    word_c = {cur_r.uid_hi[31:0], cur_r.uid_lo[63:32]};
      6'd10:   word_c = {cur_r.uid_lo[31:0], 32'h0};
      default: word_c = 64'h0;
    endcase
  end

  always_comb begin
    cur_nxt    = cur_r;
    active_nxt = active_r;
    idx_nxt    = idx_r;
    strobe_nxt = active_r;
    word_nxt   = is_err ? 64'h0 : word_c;
    oidx_nxt   = idx_r;
    last_nxt   = is_last;
    status_nxt = cur_r.status;
    chk_nxt    = is_err ? 32'h0 : cur_r.chk;

    if (active_r) begin
      idx_nxt = idx_r + 1'b1;
    end
    // The next footer starts right behind the final beat of this one.
    if (pop) begin
      cur_nxt    = head;
      active_nxt = 1'b1;
      idx_nxt    = '0;
    end else if (is_last) begin
      active_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    idx_r    <= idx_nxt;
    word_r   <= word_nxt;
    oidx_r   <= oidx_nxt;
    last_r   <= last_nxt;
    status_r <= status_nxt;
    chk_r    <= chk_nxt;
  end

  assign out_strobe      = strobe_r;
  assign out_footer_word = word_r;
  assign out_word_index  = oidx_r;
  assign out_last        = last_r;
  assign out_status      = status_r;
  assign out_checksum    = chk_r;

  a_last_place: assert property (@(posedge clk) disable iff (!rst_n)
      out_strobe && out_last |->
        (out_word_index == IDX_W'(FTR_WORDS - 1)) || (out_status != ST_OK))
    else $error("last beat at the wrong word");

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
      out_strobe && (out_status != ST_OK) |->
        out_last && (out_word_index == '0) && (out_footer_word == 64'h0))
    else $error("error result is not a single zero beat");

  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
      out_strobe && !out_last |=>
        out_strobe && (out_word_index == IDX_W'($past(out_word_index) + 1'b1)))
    else $error("footer beats not contiguous");

  a_chk_steady: assert property (@(posedge clk) disable iff (!rst_n)
      out_strobe && !out_last |=> $stable(out_checksum))
    else $error("checksum changed within a footer");

endmodule

// File: rtl/core/fixed_vhd_footer_builder_unit.sv
// Flow: a valid size gives its first footer beat after a reciprocal step for the track
// counts and then a 28-step cylinder division; an invalid size skips both steps.
// Throughput: 64 beats per valid footer and a single beat for an invalid one, one per cycle;
// the front end takes a new item only after it has queued the last one, while a two-entry queue feeds
// the beat generator, so footers stream back to back. The receiver cannot stall.
// Reset: synchronous, active low; clears the front state, the queue and the output strobe.
module fixed_vhd_footer_builder_unit
  import fvhd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [63:0]       in_raw_size,
  input  logic [62:0]       in_unix_time,
  input  logic [63:0]       in_uid_high,
  input  logic [63:0]       in_uid_low,
  output logic              out_strobe,
  output logic [63:0]       out_footer_word,
  output logic [IDX_W-1:0]  out_word_index,
  output logic              out_last,
  output logic [1:0]        out_status,
  output logic [31:0]       out_checksum
);

  logic        q_full;
  logic        q_push;
  fvhd_entry_t q_data;
  logic        q_pop;
  logic        q_valid;
  fvhd_entry_t q_head;

  fvhd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_raw_size  (in_raw_size),
    .in_unix_time (in_unix_time),
    .in_uid_high  (in_uid_high),
    .in_uid_low   (in_uid_low),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_data)
  );

  fvhd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  fvhd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (q_valid),
    .head            (q_head),
    .pop             (q_pop),
    .out_strobe      (out_strobe),
    .out_footer_word (out_footer_word),
    .out_word_index  (out_word_index),
    .out_last        (out_last),
    .out_status      (out_status),
    .out_checksum    (out_checksum)
  );

endmodule
